// File: rtl/frr_pkg.sv
`default_nettype none

package frr_pkg;

  localparam logic [7:0] ORDER_BYTE = 8'h01;
  localparam logic [7:0] SUM_INVERT = 8'hFF;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_EXPECTED_COMMAND = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_PAYLOAD = 3'd4;

  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_HDR2 = 6'b000100,
    PH_HDR3 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_CSUM = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HEADER = 2'd1,
    ST_CSUM   = 2'd2,
    ST_LONG   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_done;
    status_e    status;
    logic [7:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/frr_core.sv
`default_nettype none

module frr_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   accept_i,
  input  wire  [7:0]            rx_byte_i,
  input  wire  [7:0]            expected_command_i,
  input  wire  [7:0]            max_payload_i,
  output frr_pkg::result_t      result_o
);
  import frr_pkg::*;

  phase_e     phase_q, phase_d;
  logic       header_bad_q, header_bad_d;
  logic [7:0] payload_length_q, payload_length_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] sum_add;

  assign sum_add = running_sum_q + rx_byte_i;

  always_comb begin
    phase_d          = phase_q;
    header_bad_d     = header_bad_q;
    payload_length_d = payload_length_q;
    bytes_left_d     = bytes_left_q;
    running_sum_d    = running_sum_q;
    result_o         = '{data_byte: 8'd0, data_valid: 1'b0, frame_done: 1'b0,
                         status: ST_OK, frame_length: 8'd0};
    unique case (phase_q)
      PH_HDR1: begin
        running_sum_d = sum_add;
        phase_d       = PH_HDR2;
      end
      PH_HDR2: begin
        running_sum_d = sum_add;
        if (rx_byte_i != ORDER_BYTE) begin
          header_bad_d = 1'b1;
        end
        phase_d = PH_HDR3;
      end
      PH_HDR3: begin
        running_sum_d    = sum_add;
        payload_length_d = rx_byte_i;
        bytes_left_d     = rx_byte_i;
        if (header_bad_q) begin
          result_o.frame_done   = 1'b1;
          result_o.status       = ST_HEADER;
          result_o.frame_length = rx_byte_i;
          phase_d               = PH_HDR0;
        end else if (rx_byte_i == 8'd0) begin
          phase_d = PH_CSUM;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_d       = sum_add;
        result_o.data_byte  = rx_byte_i;
        result_o.data_valid = 1'b1;
        bytes_left_d        = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd1) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        result_o.frame_done   = 1'b1;
        result_o.frame_length = payload_length_q;
        if (rx_byte_i != (running_sum_q ^ SUM_INVERT)) begin
          result_o.status = ST_CSUM;
        end else if (payload_length_q > max_payload_i) begin
          result_o.status = ST_LONG;
        end else begin
          result_o.status = ST_OK;
        end
        phase_d = PH_HDR0;
      end
      default: begin
        running_sum_d    = rx_byte_i;
        header_bad_d     = (rx_byte_i != expected_command_i);
        payload_length_d = 8'd0;
        bytes_left_d     = 8'd0;
        phase_d          = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HDR0;
      header_bad_q     <= 1'b0;
      payload_length_q <= 8'd0;
      bytes_left_q     <= 8'd0;
      running_sum_q    <= 8'd0;
    end else if (accept_i) begin
      phase_q          <= phase_d;
      header_bad_q     <= header_bad_d;
      payload_length_q <= payload_length_d;
      bytes_left_q     <= bytes_left_d;
      running_sum_q    <= running_sum_d;
    end
  end

  a_csum_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_CSUM |=> phase_q == PH_HDR0)
    else $error("checksum beat did not return to header start");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(phase_q) && $stable(running_sum_q) && $stable(bytes_left_q))
    else $error("frame state changed without an accepted beat");

  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_DATA && bytes_left_q == 8'd1 |=> phase_q == PH_CSUM)
    else $error("last payload beat did not lead to the checksum");

  a_good_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_HDR3 && !header_bad_q
    |=> phase_q == PH_DATA || phase_q == PH_CSUM)
    else $error("good header did not lead to payload or checksum");

endmodule

`default_nettype wire

// File: rtl/frr_out_stage.sv
`default_nettype none

module frr_out_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire frr_pkg::result_t in_result_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output frr_pkg::result_t      out_result_o
);
  import frr_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      result_q <= in_result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

`default_nettype wire

// File: rtl/framed_reply_receiver.sv
// Channel   Dir  Handshake                       Content
// s_axis    in   s_axis_tvalid / s_axis_tready   one received link byte per beat
// m_axis    out  m_axis_tvalid / m_axis_tready   one result per input beat
// apb       in   psel, penable, pwrite, pready   expected_command at 0x0, max_payload at 0x4
//
// Each byte is decoded in the cycle it is accepted and its result is held in a single
// output register, so the block sustains one byte per clock while m_axis_tready is high.
// The result beat is offered in the cycle after its input beat is accepted.
// A stalled output register holds its result and blocks input until taken.
// Reset clears the deframing state and loads max_payload with 255.
`default_nettype none

module framed_reply_receiver (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [7:0] data_byte, [9:8] status, [17:10] frame_length, [23:18] zero
  output logic [frr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,   // frame_done
  output logic [0:0]                        m_axis_tuser,   // [0] data_valid
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [frr_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [frr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [frr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import frr_pkg::*;

  logic [7:0] expected_command_q;
  logic [7:0] max_payload_q;
  logic       wr_en;
  logic       accept;
  result_t    core_result;
  result_t    out_result;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_command_q <= 8'd0;
      max_payload_q      <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      unique case ({paddr[APB_ADDR_W-1], 2'b00})
        ADDR_EXPECTED_COMMAND: expected_command_q <= pwdata[7:0];
        ADDR_MAX_PAYLOAD:      max_payload_q      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case ({paddr[APB_ADDR_W-1], 2'b00})
      ADDR_EXPECTED_COMMAND: prdata = {{(APB_DATA_W-8){1'b0}}, expected_command_q};
      ADDR_MAX_PAYLOAD:      prdata = {{(APB_DATA_W-8){1'b0}}, max_payload_q};
      default:               prdata = '0;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  frr_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .rx_byte_i          (s_axis_tdata),
    .expected_command_i (expected_command_q),
    .max_payload_i      (max_payload_q),
    .result_o           (core_result)
  );

  frr_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_result_i  (core_result),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_result)
  );

  assign m_axis_tdata = {6'd0, out_result.frame_length, out_result.status,
                         out_result.data_byte};
  assign m_axis_tlast = out_result.frame_done;
  assign m_axis_tuser = out_result.data_valid;

endmodule

`default_nettype wire
